// ===== src/lrs_pkg.sv =====
`timescale 1ns / 1ps
package lrs_pkg;

    localparam int COORD_W    = 12;
    localparam int AREA_W     = 25;
    localparam int SUM_W      = 36;
    localparam int LABEL_W    = 10;
    localparam int EXT_W      = 11;
    localparam int REQ_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 112;

    localparam logic [AREA_W-1:0] AREA_CAP = 25'h100_0000;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACC   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic capture;
        logic ext_clr;
        logic sweep_wr;
        logic rd_en;
        logic upd_wr;
        logic set_ovf;
        logic div_load;
        logic div_step;
        logic out_load;
    } lrs_cmd_t;

    typedef struct packed {
        logic req_clear;
        logic req_acc;
        logic req_read;
        logic fg;
        logic lab_ok;
        logic sweep_last;
        logic div_last;
        logic out_free;
    } lrs_stat_t;

endpackage

// ===== src/lrs_ram.sv =====
`timescale 1ns / 1ps
module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/lrs_ctrl.sv =====
`timescale 1ns / 1ps
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lrs_stat_t stat,
    output lrs_cmd_t  cmd
);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    priority if (stat.req_clear) begin
                        cmd.ext_clr = 1'b1;
                        state_next  = ST_SWEEP;
                    end else if (stat.req_acc && stat.fg && stat.lab_ok) begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_UPD;
                    end else if (stat.req_acc && stat.fg) begin
                        cmd.set_ovf = 1'b1;
                    end else if (stat.req_read) begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_RDATA;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UPD: begin
                cmd.upd_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RDATA: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

endmodule

// ===== src/lrs_dpath.sv =====
`timescale 1ns / 1ps
module lrs_dpath
    import lrs_pkg::*;
#(
    parameter int MAX_LABELS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  lrs_cmd_t              cmd,
    output lrs_stat_t             stat
);

    localparam int ADDR_W  = $clog2(MAX_LABELS);
    localparam int ENT_W   = AREA_W + 2 * SUM_W + 4 * COORD_W;
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    // entry word, low to high: area, sum x, sum y, left, right, top, bottom
    localparam int SX_LO   = AREA_W;
    localparam int SY_LO   = SX_LO + SUM_W;
    localparam int LF_LO   = SY_LO + SUM_W;
    localparam int RT_LO   = LF_LO + COORD_W;
    localparam int TP_LO   = RT_LO + COORD_W;
    localparam int BT_LO   = TP_LO + COORD_W;

    // input unpack
    logic [REQ_W-1:0]   in_req;
    logic [LABEL_W-1:0] in_label;
    logic [COORD_W-1:0] in_x, in_y;
    logic               in_bg;

    assign in_req   = s_tuser[1:0];
    assign in_bg    = s_tuser[2];
    assign in_label = s_tdata[9:0];
    assign in_x     = s_tdata[21:10];
    assign in_y     = s_tdata[33:22];

    logic [LABEL_W-1:0] lab_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic               lab_ok_reg;
    logic [ADDR_W-1:0]  sweep_cnt_reg;
    logic [EXT_W-1:0]   ext_reg;
    logic               ovf_reg;
    logic               in_lab_ok;

    assign in_lab_ok = (32'(in_label) < 32'(MAX_LABELS));

    // table
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata, upd_word;

    assign ram_we    = cmd.sweep_wr | cmd.upd_wr;
    assign ram_waddr = cmd.sweep_wr ? sweep_cnt_reg : ADDR_W'(lab_reg);
    assign ram_wdata = cmd.sweep_wr ? '0 : upd_word;

    lrs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LABELS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ADDR_W'(in_label)),
        .rdata (ram_rdata)
    );

    logic [AREA_W-1:0]  e_area;
    logic [SUM_W-1:0]   e_sx, e_sy;
    logic [COORD_W-1:0] e_left, e_right, e_top, e_bot;

    assign e_area  = ram_rdata[AREA_W-1:0];
    assign e_sx    = ram_rdata[SY_LO-1:SX_LO];
    assign e_sy    = ram_rdata[LF_LO-1:SY_LO];
    assign e_left  = ram_rdata[RT_LO-1:LF_LO];
    assign e_right = ram_rdata[TP_LO-1:RT_LO];
    assign e_top   = ram_rdata[BT_LO-1:TP_LO];
    assign e_bot   = ram_rdata[ENT_W-1:BT_LO];

    // pixel update
    logic               first, sat;
    logic [AREA_W-1:0]  n_area;
    logic [SUM_W-1:0]   n_sx, n_sy;
    logic [COORD_W-1:0] n_left, n_right, n_top, n_bot;

    always_comb begin
        first   = (e_area == '0);
        sat     = (e_area == AREA_CAP);
        n_left  = (first || x_reg < e_left)  ? x_reg : e_left;
        n_right = (first || x_reg > e_right) ? x_reg : e_right;
        n_top   = first ? y_reg : e_top;
        n_bot   = (first || y_reg > e_bot)   ? y_reg : e_bot;
        n_area  = sat ? e_area : e_area + AREA_W'(1);
        n_sx    = sat ? e_sx : e_sx + SUM_W'(x_reg);
        n_sy    = sat ? e_sy : e_sy + SUM_W'(y_reg);
        upd_word = {n_bot, n_top, n_right, n_left, n_sy, n_sx, n_area};
    end

    // read path: latched entry and two restoring divider lanes
    logic               rd_zero_reg;
    logic [AREA_W-1:0]  rd_area_reg;
    logic [COORD_W-1:0] rd_left_reg, rd_right_reg, rd_top_reg, rd_bot_reg;
    logic [SUM_W-1:0]   dvd_x_reg, dvd_y_reg;
    logic [AREA_W-1:0]  rem_x_reg, rem_y_reg;
    logic [COORD_W-1:0] q_x_reg, q_y_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [AREA_W:0]    tr_x, tr_y;
    logic               ge_x, ge_y;

    always_comb begin
        tr_x = {rem_x_reg, dvd_x_reg[SUM_W-1]};
        tr_y = {rem_y_reg, dvd_y_reg[SUM_W-1]};
        ge_x = (tr_x >= {1'b0, rd_area_reg});
        ge_y = (tr_y >= {1'b0, rd_area_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lab_reg    <= in_label;
            x_reg      <= in_x;
            y_reg      <= in_y;
            lab_ok_reg <= in_lab_ok;
        end
        if (cmd.div_load) begin
            rd_zero_reg  <= !lab_ok_reg || (e_area == '0);
            rd_area_reg  <= e_area;
            rd_left_reg  <= e_left;
            rd_right_reg <= e_right;
            rd_top_reg   <= e_top;
            rd_bot_reg   <= e_bot;
            dvd_x_reg    <= e_sx;
            dvd_y_reg    <= e_sy;
            rem_x_reg    <= '0;
            rem_y_reg    <= '0;
            q_x_reg      <= '0;
            q_y_reg      <= '0;
        end else if (cmd.div_step) begin
            dvd_x_reg <= {dvd_x_reg[SUM_W-2:0], 1'b0};
            dvd_y_reg <= {dvd_y_reg[SUM_W-2:0], 1'b0};
            rem_x_reg <= ge_x ? AREA_W'(tr_x - {1'b0, rd_area_reg}) : tr_x[AREA_W-1:0];
            rem_y_reg <= ge_y ? AREA_W'(tr_y - {1'b0, rd_area_reg}) : tr_y[AREA_W-1:0];
            q_x_reg   <= {q_x_reg[COORD_W-2:0], ge_x};
            q_y_reg   <= {q_y_reg[COORD_W-2:0], ge_y};
        end
    end

    // control registers
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
            ext_reg       <= '0;
            ovf_reg       <= 1'b0;
            dcnt_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.sweep_wr) begin
                sweep_cnt_reg <= stat.sweep_last ? '0 : sweep_cnt_reg + ADDR_W'(1);
            end
            if (cmd.ext_clr) begin
                ext_reg <= '0;
            end else if (cmd.upd_wr && (EXT_W'(lab_reg) + EXT_W'(1) > ext_reg)) begin
                ext_reg <= EXT_W'(lab_reg) + EXT_W'(1);
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.div_load) begin
                dcnt_reg <= DCNT_W'(SUM_W);
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        m_tdata_next          = '0;
        m_tdata_next[108]     = ovf_reg;
        m_tdata_next[107:97]  = ext_reg;
        if (!rd_zero_reg) begin
            m_tdata_next[24:0]  = rd_area_reg;
            m_tdata_next[36:25] = rd_left_reg;
            m_tdata_next[48:37] = rd_right_reg;
            m_tdata_next[60:49] = rd_top_reg;
            m_tdata_next[72:61] = rd_bot_reg;
            m_tdata_next[84:73] = q_x_reg;
            m_tdata_next[96:85] = q_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stat.req_clear  = (in_req == REQ_CLEAR);
        stat.req_acc    = (in_req == REQ_ACC);
        stat.req_read   = (in_req == REQ_READ);
        stat.fg         = !in_bg;
        stat.lab_ok     = in_lab_ok;
        stat.sweep_last = (sweep_cnt_reg == ADDR_W'(MAX_LABELS - 1));
        stat.div_last   = (dcnt_reg == DCNT_W'(1));
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== src/labeled_region_statistics.sv =====
`timescale 1ns / 1ps
// Per-label region statistics over a raster stream. Each item is a clear, an accumulate
// (one labeled pixel) or a read of one label's entry; only reads produce a result item.
// Timing: after reset, and after every clear item, the table is zeroed by a sweep over
// all MAX_LABELS entries during which no item is taken. A foreground pixel with an
// in-range label is accepted with a table read, then written back (the table RAM has a
// registered read); background pixels, dropped labels and unused codes are not written
// back. A read is accepted with a table read, the entry is latched, a bit-serial
// restoring divider forms both centroids in parallel and the result register is loaded
// once free; the result register lets new items be accepted while a result waits for
// m_tready. Foreground pixels with labels at or above MAX_LABELS are dropped and set a
// sticky overflow flag; empty or out-of-range entries read as zero in all entry fields.
module labeled_region_statistics
    import lrs_pkg::*;
#(
    parameter int MAX_LABELS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // label[9:0], pos_x[21:10], pos_y[33:22], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0], is_background[2]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_count[24:0], left_x[36:25], right_x[48:37], top_y[60:49],
    // bottom_y[72:61], centroid_x[84:73], centroid_y[96:85],
    // highest_label_plus_1[107:97], label_overflow[108], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    lrs_cmd_t  cmd;
    lrs_stat_t stat;

    // sequencer
    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, update logic, divider and result register
    lrs_dpath #(
        .MAX_LABELS (MAX_LABELS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // a clear starts the table sweep, so nothing is taken in the next cycle
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1:0] == REQ_CLEAR) |=> !s_tready)
        else $error("item accepted right after a clear");

    // only reads make results: a non-read item never raises m_tvalid in the next cycle
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1:0] != REQ_READ && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a non-read item");

    // no item is taken in the cycle after a read is accepted
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1:0] == REQ_READ) |=> !s_tready)
        else $error("item accepted while a read is being processed");
`endif

endmodule
